// File: hw/rtl/exti_pkg.sv
// Shared types and codes for the external interrupt edge controller.
// Holds the request and response payload structs, command codes and register map.
// No dependencies.
package exti_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register map
    localparam logic [3:0] REG_MASK    = 4'd0;
    localparam logic [3:0] REG_RISE    = 4'd1;
    localparam logic [3:0] REG_FALL    = 4'd2;
    localparam logic [3:0] REG_SWTRIG  = 4'd3;
    localparam logic [3:0] REG_PENDING = 4'd4;
    localparam logic [3:0] REG_PSEL0   = 4'd5;
    localparam logic [3:0] REG_PSEL3   = 4'd8;

    // Port codes wired to pin inputs
    localparam logic [3:0] PORT_A = 4'd0;
    localparam logic [3:0] PORT_B = 4'd1;
    localparam logic [3:0] PORT_C = 4'd2;
    localparam logic [3:0] PORT_D = 4'd3;
    localparam logic [3:0] PORT_E = 4'd4;

    localparam int MAX_LINES = 16;
    localparam int NUM_WORDS = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  reg_sel;
        logic [15:0] write_data;
        logic [15:0] port_a_pins;
        logic [15:0] port_b_pins;
        logic [15:0] port_c_pins;
        logic [15:0] port_d_pins;
        logic [15:0] port_e_pins;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] irq_lines;
    } rsp_t;

endpackage

// File: hw/rtl/external_interrupt_edge_controller.sv
// External interrupt edge controller: register bank, edge detect and pending logic.
// Depends on exti_pkg for payload structs and codes.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one command per transfer:
//   a pin sample tick, a register write or a register read. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one transfer per command with the
//   read data (zero unless a read) and the interrupt vector, pending AND mask,
//   as it stands after the command.
//   Each command passes from the input register through the update logic into
//   the response register, and rsp_valid rises as the command enters the
//   response register. Throughput is one command per cycle while the receiver
//   does not stall; the register state updates as a command moves from the
//   input register into the response register.
//   When the receiver stalls, the response register holds and the input
//   register still takes one more command; req_ready drops only when both
//   are full and rsp_ready is low.
//   Reset clears the state registers: mask, enables, software triggers, pending
//   bits, previous pin levels and all port selects (port a). The first tick
//   after reset sees any high line as a rising edge.
module external_interrupt_edge_controller
    import exti_pkg::*;
#(
    parameter int NUM_LINES = 16,
    parameter int NUM_PORTS = 5
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [15:0] LINE_MASK = 16'((32'd1 << NUM_LINES) - 32'd1);
    localparam logic [4:0]  PORT_LIMIT = 5'(NUM_PORTS);

    // Pipeline control and payload
    logic req_valid_reg;
    req_t req_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic advance;

    // Architectural state
    logic [15:0] mask_reg, mask_next;
    logic [15:0] rise_reg, rise_next;
    logic [15:0] fall_reg, fall_next;
    logic [15:0] soft_reg, soft_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] prev_reg, prev_next;
    logic [3:0]  psel_reg  [NUM_LINES];
    logic [3:0]  psel_next [NUM_LINES];

    // Combinational helpers
    logic [15:0] sel_words [NUM_WORDS];
    logic [15:0] level;
    logic [15:0] rise_evt;
    logic [15:0] fall_evt;
    logic [15:0] read_data;
    logic [15:0] wd_lines;

    // Handshake: move stage 1 forward whenever the response slot is free
    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Hold the accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
    end

    // Gather port select words and sampled levels per line
    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            sel_words[w] = '0;
        end
        level = '0;
        for (int l = 0; l < NUM_LINES; l++)
        begin
            sel_words[l / 4][4 * (l % 4) +: 4] = psel_reg[l];
            if ({1'b0, psel_reg[l]} < PORT_LIMIT)
            begin
                case (psel_reg[l])
                    PORT_A:  level[l] = req_reg.port_a_pins[l];
                    PORT_B:  level[l] = req_reg.port_b_pins[l];
                    PORT_C:  level[l] = req_reg.port_c_pins[l];
                    PORT_D:  level[l] = req_reg.port_d_pins[l];
                    PORT_E:  level[l] = req_reg.port_e_pins[l];
                    default: level[l] = 1'b0;
                endcase
            end
        end
        rise_evt = level & ~prev_reg;
        fall_evt = ~level & prev_reg;
    end

    // Apply the command to the register state and form the response
    always_comb
    begin
        mask_next    = mask_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        soft_next    = soft_reg;
        pending_next = pending_reg;
        prev_next    = prev_reg;
        for (int l = 0; l < NUM_LINES; l++)
        begin
            psel_next[l] = psel_reg[l];
        end
        read_data = '0;
        wd_lines  = req_reg.write_data & LINE_MASK;

        case (req_reg.cmd)
            CMD_TICK:
            begin
                pending_next = pending_reg
                             | (((rise_evt & rise_reg) | (fall_evt & fall_reg)) & LINE_MASK);
                prev_next    = level;
            end
            CMD_WRITE:
            begin
                case (req_reg.reg_sel) inside
                    REG_MASK:    mask_next = wd_lines;
                    REG_RISE:    rise_next = wd_lines;
                    REG_FALL:    fall_next = wd_lines;
                    REG_SWTRIG:
                    begin
                        soft_next    = soft_reg | wd_lines;
                        pending_next = pending_reg | wd_lines;
                    end
                    REG_PENDING:
                    begin
                        soft_next    = soft_reg & ~wd_lines;
                        pending_next = pending_reg & ~wd_lines;
                    end
                    [REG_PSEL0:REG_PSEL3]:
                    begin
                        for (int l = 0; l < NUM_LINES; l++)
                        begin
                            if (req_reg.reg_sel == REG_PSEL0 + 4'(l / 4))
                            begin
                                psel_next[l] = req_reg.write_data[4 * (l % 4) +: 4];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (req_reg.reg_sel) inside
                    REG_MASK:    read_data = mask_reg;
                    REG_RISE:    read_data = rise_reg;
                    REG_FALL:    read_data = fall_reg;
                    REG_SWTRIG:  read_data = soft_reg;
                    REG_PENDING: read_data = pending_reg;
                    [REG_PSEL0:REG_PSEL3]:
                    begin
                        read_data = sel_words[2'(req_reg.reg_sel - REG_PSEL0)];
                    end
                    default:     read_data = '0;
                endcase
            end
            default: ;
        endcase
    end

    // Commit state as the command moves into the response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            soft_reg    <= '0;
            pending_reg <= '0;
            prev_reg    <= '0;
            for (int l = 0; l < NUM_LINES; l++)
            begin
                psel_reg[l] <= PORT_A;
            end
        end
        else if (advance)
        begin
            mask_reg    <= mask_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            soft_reg    <= soft_next;
            pending_reg <= pending_next;
            prev_reg    <= prev_next;
            for (int l = 0; l < NUM_LINES; l++)
            begin
                psel_reg[l] <= psel_next[l];
            end
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg.read_data <= read_data;
            rsp_reg.irq_lines <= pending_next & mask_next;
        end
    end

    // State only moves together with the response, so a waiting response
    // always matches the live interrupt vector
    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.irq_lines == (pending_reg & mask_reg)))
        else $error("irq_lines out of step with pending and mask");

    // A software trigger is always backed by a pending bit
    a_soft_implies_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (soft_reg & ~pending_reg) == 16'd0)
        else $error("software trigger set without pending bit");

    // Absent lines never hold state
    a_absent_lines_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((pending_reg | mask_reg | prev_reg) & ~LINE_MASK) == 16'd0)
        else $error("state bit set on an absent line");

endmodule
